/* sv/rtdi_pkg.sv */
// ---------------------------------------------------------------------------
// Ready-to-drive interlock package
// Types, register indexes and reset values shared across the interlock.
// ---------------------------------------------------------------------------
package rtdi_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_BRAKE_THRESHOLD = 8'd0;
  localparam logic [7:0] CFG_IMD_BLANK_MS    = 8'd1;
  localparam logic [7:0] CFG_BLINK_MS        = 8'd2;
  localparam logic [7:0] CFG_SOUND_MS        = 8'd3;

  // Register values after reset.
  localparam logic [12:0] BRAKE_THRESHOLD_RST = 13'd1000;
  localparam logic [31:0] IMD_BLANK_MS_RST    = 32'd30000;
  localparam logic [15:0] BLINK_MS_RST        = 16'd250;
  localparam logic [15:0] SOUND_MS_RST        = 16'd1500;

  // Isolation low readings needed to latch the fault.
  localparam logic [1:0] IMD_LOW_LIMIT = 2'd2;

  // One tick from the vehicle.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        shutdown_closed;
    logic        imd_ok_raw;
    logic        bms_fault;
    logic [11:0] brake_a;
    logic [11:0] brake_b;
    logic        button_pressed;
  } tick_t;

  // One result per tick.
  typedef struct packed {
    logic drive_mode;
    logic bspd_on_sent;
    logic bspd_off_sent;
    logic light_sent;
    logic light_value;
    logic bms_status_sent;
    logic imd_status_sent;
    logic sound_sent;
    logic sound_value;
    logic clear_burst;
  } result_t;

  // Configuration write beat.
  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] value;
  } cfg_beat_t;

  // Current configuration.
  typedef struct packed {
    logic [12:0] brake_threshold;
    logic [31:0] imd_blank_ms;
    logic [15:0] blink_ms;
    logic [15:0] sound_ms;
  } cfg_regs_t;

  // Interlock state carried from tick to tick.
  typedef struct packed {
    logic        mode;
    logic [1:0]  imd_low_count;
    logic        imd_latched;
    logic        start_done;
    logic        light_level;
    logic        blink_phase;
    logic [31:0] last_blink_ms;
    logic [31:0] sound_start_ms;
  } state_t;

endpackage

/* sv/rtdi_stream_if.sv */
// ---------------------------------------------------------------------------
// Ready-to-drive interlock stream interface
// Valid/ready channel with a typed payload, used for ticks, results and
// configuration writes.
// ---------------------------------------------------------------------------
interface rtdi_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/rtdi_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Ready-to-drive interlock configuration registers
// Holds the four configuration registers and takes one write beat per cycle.
// ---------------------------------------------------------------------------
module rtdi_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  rtdi_stream_if.sink         cfg,
  output rtdi_pkg::cfg_regs_t regs
);
  import rtdi_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.brake_threshold <= BRAKE_THRESHOLD_RST;
      regs.imd_blank_ms    <= IMD_BLANK_MS_RST;
      regs.blink_ms        <= BLINK_MS_RST;
      regs.sound_ms        <= SOUND_MS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_BRAKE_THRESHOLD: regs.brake_threshold <= cfg.data.value[12:0];
        CFG_IMD_BLANK_MS:    regs.imd_blank_ms    <= cfg.data.value;
        CFG_BLINK_MS:        regs.blink_ms        <= cfg.data.value[15:0];
        CFG_SOUND_MS:        regs.sound_ms        <= cfg.data.value[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/rtdi_step.sv */
// ---------------------------------------------------------------------------
// Ready-to-drive interlock step logic
// Combinational evaluation of one tick: next state and the result beat.
// ---------------------------------------------------------------------------
module rtdi_step (
  input  rtdi_pkg::cfg_regs_t regs,
  input  rtdi_pkg::state_t    cur,
  input  rtdi_pkg::tick_t     tick,
  output rtdi_pkg::state_t    nxt,
  output rtdi_pkg::result_t   res
);
  import rtdi_pkg::*;

  logic        imd_ok;
  logic        latched;
  logic [31:0] blink_diff;
  logic [31:0] sound_diff;
  logic [12:0] brake_sum;
  logic        enter;

  assign brake_sum  = {1'b0, tick.brake_a} + {1'b0, tick.brake_b};
  assign blink_diff = tick.now_ms - cur.last_blink_ms;

  always_comb begin
    nxt = cur;
    res = '0;

    // Isolation reading counts only after the blanking window.
    imd_ok = (tick.now_ms > regs.imd_blank_ms) ? tick.imd_ok_raw : 1'b1;
    if (!imd_ok && (cur.imd_low_count < IMD_LOW_LIMIT)) begin
      nxt.imd_low_count = cur.imd_low_count + 2'd1;
    end
    latched = cur.imd_latched | (nxt.imd_low_count == IMD_LOW_LIMIT);
    nxt.imd_latched = latched;

    // Fault-circuit enable while the shutdown circuit is closed and no isolation fault is latched.
    res.bspd_on_sent = tick.shutdown_closed & ~latched;

    // Fault light blinking, or light off and fault circuit disabled.
    if (latched || tick.bms_fault) begin
      if (blink_diff > {16'd0, regs.blink_ms}) begin
        if (cur.blink_phase) begin
          nxt.light_level = ~cur.light_level;
          nxt.blink_phase = 1'b0;
        end else begin
          nxt.blink_phase = 1'b1;
        end
        res.light_sent    = 1'b1;
        res.light_value   = nxt.light_level;
        nxt.last_blink_ms = tick.now_ms;
      end else begin
        nxt.light_level   = 1'b0;
        res.bspd_off_sent = 1'b1;
      end
    end

    // Start-up clear burst on the first tick only.
    res.clear_burst = ~cur.start_done;
    nxt.start_done  = 1'b1;

    res.bms_status_sent = tick.bms_fault;
    res.imd_status_sent = latched;

    // Entry into drive mode starts the sound.
    enter = ~cur.mode && (brake_sum > regs.brake_threshold) && tick.button_pressed &&
            tick.shutdown_closed && ~latched;
    if (enter) begin
      nxt.mode           = 1'b1;
      res.sound_sent     = 1'b1;
      res.sound_value    = 1'b1;
      nxt.sound_start_ms = tick.now_ms;
    end

    // Stop-sound frame once the sound time has run out.
    sound_diff = tick.now_ms - nxt.sound_start_ms;
    if (sound_diff > {16'd0, regs.sound_ms}) begin
      res.sound_sent  = 1'b1;
      res.sound_value = 1'b0;
    end

    // Leave drive when the shutdown circuit opens or a fault latches.
    if (nxt.mode && (!tick.shutdown_closed || latched)) begin
      nxt.mode = 1'b0;
    end
    res.drive_mode = nxt.mode;
  end

endmodule

/* sv/ready_to_drive_interlock.sv */
// ---------------------------------------------------------------------------
// Ready-to-drive interlock
// Tick input register, interlock state, step logic and result register.
// ---------------------------------------------------------------------------
//
//   Channel  Role    Payload     Beat
//   tick     sink    tick_t      one tick of vehicle inputs
//   result   source  result_t    one result per tick
//   cfg      sink    cfg_beat_t  one register write, always ready
//
// A tick beat is registered in the tick register, evaluated by the step logic
// and its result is registered in the result register.
// One tick is taken per cycle while the result side does not stall; the step
// logic between the tick register and the result register is combinational.
// A stall on result holds the result register and the tick register, and
// tick.ready falls only when both are full.
// rst is synchronous and returns the state and registers to their defaults.
// ---------------------------------------------------------------------------
module ready_to_drive_interlock (
  input logic         clk,
  input logic         rst,
  rtdi_stream_if.sink   tick,
  rtdi_stream_if.source result,
  rtdi_stream_if.sink   cfg
);
  import rtdi_pkg::*;

  cfg_regs_t regs;
  tick_t     tick_q;
  logic      tick_valid;
  state_t    state;
  state_t    state_next;
  result_t   res_next;
  result_t   res_q;
  logic      res_valid;
  logic      advance;

  rtdi_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rtdi_step u_step (
    .regs (regs),
    .cur  (state),
    .tick (tick_q),
    .nxt  (state_next),
    .res  (res_next)
  );

  // The held tick moves on when the result register is free or being taken.
  assign advance    = tick_valid && (!res_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  // Tick input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      tick_q <= tick.data;
    end
  end

  // Interlock state updates once per evaluated tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_q;

  // Drive mode is never held with an isolation fault latched.
  a_mode_no_fault: assert property (@(posedge clk) disable iff (rst)
    state.mode |-> !state.imd_latched)
    else $error("drive mode held with isolation fault latched");

  // The latch is set only once the low count has reached its limit.
  a_latch_count: assert property (@(posedge clk) disable iff (rst)
    state.imd_latched |-> (state.imd_low_count == IMD_LOW_LIMIT))
    else $error("isolation latch set below count limit");

  // The first evaluated tick ends the start-up phase.
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (advance && !state.start_done) |=> state.start_done)
    else $error("start-up phase not closed after first tick");

  // A waiting tick is not lost while the result side stalls.
  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !advance) |=> tick_valid)
    else $error("held tick dropped during stall");

endmodule
